[hw/rtl/mclb_pkg.sv]
// Package for the multi-channel LED blinker.
// Holds the operation codes, the controller state type and the command struct.
// No dependencies.
package mclb_pkg;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_CONFIG = 1'b1;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_REPORT
	} ctrl_state_t;

	typedef struct packed {
		logic tick;
		logic cfg;
	} dp_cmd_t;

endpackage

[hw/rtl/mclb_ctrl.sv]
// Controller of the multi-channel LED blinker.
// Accepts beats, issues tick and configure commands and marks the result beat.
// Depends on mclb_pkg.
module mclb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	output logic              busy,
	output logic              done,
	output mclb_pkg::dp_cmd_t cmd
);

	mclb_pkg::ctrl_state_t state_q;
	mclb_pkg::ctrl_state_t state_d;
	logic                  accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mclb_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b0;
		done     = 1'b0;
		accept   = 1'b0;
		cmd.tick = 1'b0;
		cmd.cfg  = 1'b0;
		case (state_q)
			mclb_pkg::ST_INIT: begin
				busy    = 1'b1;
				state_d = mclb_pkg::ST_IDLE;
			end
			mclb_pkg::ST_IDLE: begin
				accept = start;
			end
			mclb_pkg::ST_REPORT: begin
				done   = 1'b1;
				accept = start;
			end
			default: begin
				busy    = 1'b1;
				state_d = mclb_pkg::ST_IDLE;
			end
		endcase
		if (accept) begin
			cmd.tick = (operation == mclb_pkg::OP_TICK);
			cmd.cfg  = (operation == mclb_pkg::OP_CONFIG);
			state_d  = mclb_pkg::ST_REPORT;
		end else if (state_q == mclb_pkg::ST_REPORT) begin
			state_d = mclb_pkg::ST_IDLE;
		end
	end

`ifndef SYNTHESIS
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.tick && cmd.cfg))
		else $error("tick and configure commands issued together");

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted beat produced no result beat");

	a_done_only_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.tick || cmd.cfg))
		else $error("result beat without a command in the cycle before");

	a_no_cmd_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(cmd.tick || cmd.cfg))
		else $error("command issued while busy");
`endif

endmodule

[hw/rtl/mclb_datapath.sv]
// Datapath of the multi-channel LED blinker.
// Per-channel limits, elapsed counters, phase and enable bits; drives the pin word.
// Depends on mclb_pkg.
module mclb_datapath #(
	parameter int CHANNELS   = 32,
	parameter int TIME_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mclb_pkg::dp_cmd_t cmd,
	input  logic [4:0]        channel,
	input  logic [15:0]       on_time,
	input  logic [15:0]       off_time,
	output logic [31:0]       pin_levels
);

	localparam int CW = TIME_WIDTH + 1;

	logic [TIME_WIDTH-1:0] on_limit_q  [CHANNELS];
	logic [TIME_WIDTH-1:0] off_limit_q [CHANNELS];
	logic [CW-1:0]         elapsed_q   [CHANNELS];
	logic [CHANNELS-1:0]   lit_q;
	logic [CHANNELS-1:0]   enabled_q;

	logic [TIME_WIDTH-1:0] on_lim;
	logic [TIME_WIDTH-1:0] off_lim;
	logic                  both_zero;

	assign on_lim    = TIME_WIDTH'(on_time);
	assign off_lim   = TIME_WIDTH'(off_time);
	assign both_zero = (on_lim == '0) && (off_lim == '0);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		logic                  sel;
		logic [TIME_WIDTH-1:0] lim;
		logic [CW-1:0]         next_cnt;
		logic                  wrap;

		assign sel      = cmd.cfg && (channel == 5'(c));
		assign lim      = lit_q[c] ? on_limit_q[c] : off_limit_q[c];
		assign next_cnt = elapsed_q[c] + CW'(1);
		assign wrap     = next_cnt > CW'(lim);

		always_ff @(posedge clk) begin
			if (sel && !both_zero) begin
				on_limit_q[c]  <= on_lim;
				off_limit_q[c] <= off_lim;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				elapsed_q[c] <= '0;
				lit_q[c]     <= 1'b0;
				enabled_q[c] <= 1'b0;
			end else if (sel) begin
				lit_q[c]     <= 1'b0;
				enabled_q[c] <= !both_zero;
			end else if (cmd.tick && enabled_q[c]) begin
				if (wrap) begin
					elapsed_q[c] <= '0;
					lit_q[c]     <= !lit_q[c];
				end else begin
					elapsed_q[c] <= next_cnt;
				end
			end
		end
	end

	always_comb begin
		pin_levels = '0;
		pin_levels[CHANNELS-1:0] = ~lit_q;
	end

endmodule

[hw/rtl/multi_channel_led_blinker_unit.sv]
// Top level of the multi-channel LED blinker.
// Instantiates mclb_ctrl and mclb_datapath; depends on mclb_pkg.
//
// Channel  | Handshake      | Payload
// input    | start / busy   | operation, channel, on_time, off_time
// result   | done (strobe)  | pin_levels
//
// Each beat is applied to the channel registers at the edge that accepts it,
// and its result beat follows in the next cycle with done high for one cycle.
// A new beat can be accepted every cycle while busy is low, also in the cycle that shows a result.
// After reset, busy is high for one cycle; the receiver cannot stall results.
module multi_channel_led_blinker_unit #(
	parameter int CHANNELS   = 32,
	parameter int TIME_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [4:0]  channel,
	input  logic [15:0] on_time,
	input  logic [15:0] off_time,
	output logic        done,
	output logic [31:0] pin_levels
);

	mclb_pkg::dp_cmd_t cmd;

	mclb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	mclb_datapath #(
		.CHANNELS   (CHANNELS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.channel    (channel),
		.on_time    (on_time),
		.off_time   (off_time),
		.pin_levels (pin_levels)
	);

endmodule
